>>> sv/dpp_pkg.sv
// Shared constants, types and arithmetic step functions for the depth-pixel-to-point unit.
package dpp_pkg;

  // Input and register field widths
  localparam int IndexBits  = 12;
  localparam int RangeBits  = 16;
  localparam int CenterBits = 16;
  localparam int FocalBits  = 20;
  localparam int XBits      = 24;
  localparam int ZBits      = 20;

  // Derived datapath widths
  localparam int OffBits   = (IndexBits + 4 > CenterBits) ? IndexBits + 4 : CenterBits;
  localparam int ABits     = OffBits + 4;
  localparam int R16Bits   = RangeBits + 4;
  localparam int BBits     = 32;
  localparam int BNBits    = OffBits + FocalBits;
  localparam int BN2Bits   = BNBits + 6;
  localparam int BSteps    = BBits;
  localparam int SqBits    = 64;
  localparam int RootBits  = 32;
  localparam int SSteps    = RootBits;
  localparam int DRemBits  = RootBits + 1;
  localparam int FNumBits  = R16Bits + BBits;
  localparam int FN2Bits   = FNumBits + 2;
  localparam int QBits     = 25;
  localparam int QSteps    = QBits;
  localparam int ZCmpBits  = (R16Bits > QBits) ? R16Bits : QBits;
  localparam int Lanes     = 3;

  // Pipeline depth: offsets, row product, row-divide setup, row divide, squares,
  // sum, square root, final products, final-divide setup, final divide, saturation
  localparam int Depth = 3 + BSteps + 2 + SSteps + 2 + QSteps + 1;

  // Limits
  localparam logic [BBits-1:0] BLimit  = 32'd3000000000;
  localparam logic [QBits-1:0] PosMax  = 25'd8388607;
  localparam logic [QBits-1:0] NegMag  = 25'd8388608;
  localparam logic [ZCmpBits-1:0] ZMax = ZCmpBits'(20'hFFFFF);

  // Register map
  localparam int AddrBits   = 5;
  localparam int RegIdxBits = AddrBits - 2;
  localparam logic [RegIdxBits-1:0] RegDepthMode = 3'd0;
  localparam logic [RegIdxBits-1:0] RegFocalX    = 3'd1;
  localparam logic [RegIdxBits-1:0] RegFocalY    = 3'd2;
  localparam logic [RegIdxBits-1:0] RegCenterX   = 3'd3;
  localparam logic [RegIdxBits-1:0] RegCenterY   = 3'd4;

  localparam logic [FocalBits-1:0]  FocalReset   = 20'd76800;
  localparam logic [CenterBits-1:0] CenterXReset = 16'd2560;
  localparam logic [CenterBits-1:0] CenterYReset = 16'd1920;

  typedef struct packed {
    logic                  depth_mode;
    logic [FocalBits-1:0]  focal_x;
    logic [FocalBits-1:0]  focal_y;
    logic [CenterBits-1:0] center_x;
    logic [CenterBits-1:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [XBits-1:0] x;
    logic [XBits-1:0] y;
    logic [ZBits-1:0] z;
    logic             clip;
  } res_t;

  // Per-pixel values carried through the front half
  typedef struct packed {
    logic                 xneg;
    logic                 yneg;
    logic [OffBits-1:0]   dxm;
    logic [OffBits-1:0]   dym;
    logic [RangeBits-1:0] rng;
  } com_t;

  typedef struct packed {
    logic [DRemBits-1:0] rem;
    logic [BBits-1:0]    rest;
    logic [BBits-1:0]    q;
    logic                over;
  } bd_t;

  typedef struct packed {
    com_t             c;
    logic [BBits-1:0] b;
  } sqc_t;

  typedef struct packed {
    logic [RootBits-1:0]   root;
    logic [RootBits+1:0]   rem;
    logic [SqBits-1:0]     rest;
  } sq_t;

  typedef struct packed {
    logic [FNumBits-1:0] n;
    logic [RootBits-1:0] d;
  } ln_t;

  typedef struct packed {
    logic [DRemBits-1:0] rem;
    logic [DRemBits-1:0] den;
    logic [QBits-1:0]    rest;
    logic [QBits-1:0]    q;
    logic                over;
  } qd_t;

  typedef struct packed {
    logic                 xneg;
    logic                 yneg;
    logic [RangeBits-1:0] rng;
  } qc_t;

  typedef struct packed {
    logic                qb;
    logic [DRemBits-1:0] rem;
  } dstep_t;

  typedef struct packed {
    logic             clip;
    logic [XBits-1:0] val;
  } sat_t;

  // One restoring-division step: shift in a numerator bit, subtract if it fits
  function automatic dstep_t div_step(input logic [DRemBits-1:0] rem,
                                      input logic [DRemBits-1:0] den,
                                      input logic nb);
    logic [DRemBits:0] sh;
    dstep_t r;
    sh = {rem, nb};
    if (sh >= {1'b0, den}) begin
      r.qb  = 1'b1;
      r.rem = DRemBits'(sh - {1'b0, den});
    end else begin
      r.qb  = 1'b0;
      r.rem = sh[DRemBits-1:0];
    end
    return r;
  endfunction

  function automatic bd_t bdiv_adv(input bd_t s, input logic [DRemBits-1:0] den);
    dstep_t st;
    bd_t r;
    st     = div_step(s.rem, den, s.rest[BBits-1]);
    r      = s;
    r.rem  = st.rem;
    r.rest = {s.rest[BBits-2:0], 1'b0};
    r.q    = {s.q[BBits-2:0], st.qb};
    return r;
  endfunction

  function automatic qd_t qdiv_adv(input qd_t s);
    dstep_t st;
    qd_t r;
    st     = div_step(s.rem, s.den, s.rest[QBits-1]);
    r      = s;
    r.rem  = st.rem;
    r.rest = {s.rest[QBits-2:0], 1'b0};
    r.q    = {s.q[QBits-2:0], st.qb};
    return r;
  endfunction

  // Set up round-to-nearest division: floor((2n + d) / 2d), quotient capped at QBits
  function automatic qd_t qdiv_setup(input ln_t l);
    logic [FN2Bits-1:0] n2;
    logic [FN2Bits-QBits-1:0] init;
    qd_t r;
    n2     = FN2Bits'({l.n, 1'b0}) + FN2Bits'(l.d);
    init   = n2[FN2Bits-1:QBits];
    r.den  = {l.d, 1'b0};
    r.over = (DRemBits'(init) >= r.den) || (init >> DRemBits) != '0;
    r.rem  = DRemBits'(init);
    r.rest = n2[QBits-1:0];
    r.q    = '0;
    return r;
  endfunction

  // One digit of the square root: bring down two bits, try 4*root + 1
  function automatic sq_t sqrt_adv(input sq_t s);
    logic [RootBits+3:0] sh;
    logic [RootBits+3:0] t;
    sq_t r;
    sh     = {s.rem, s.rest[SqBits-1:SqBits-2]};
    t      = {2'b00, s.root, 2'b01};
    r.rest = {s.rest[SqBits-3:0], 2'b00};
    if (sh >= t) begin
      r.rem  = (RootBits+2)'(sh - t);
      r.root = {s.root[RootBits-2:0], 1'b1};
    end else begin
      r.rem  = sh[RootBits+1:0];
      r.root = {s.root[RootBits-2:0], 1'b0};
    end
    return r;
  endfunction

  // Saturate a sign and capped magnitude to a signed 24-bit coordinate
  function automatic sat_t sat_s24(input logic neg, input logic over,
                                   input logic [QBits-1:0] q);
    sat_t r;
    r.clip = 1'b0;
    if (neg && (over || q != '0)) begin
      if (over || q > NegMag) begin
        r.val  = {1'b1, {(XBits-1){1'b0}}};
        r.clip = 1'b1;
      end else begin
        r.val = XBits'(~q + QBits'(1));
      end
    end else begin
      if (over || q > PosMax) begin
        r.val  = {1'b0, {(XBits-1){1'b1}}};
        r.clip = 1'b1;
      end else begin
        r.val = q[XBits-1:0];
      end
    end
    return r;
  endfunction

endpackage

>>> sv/dpp_pipe.sv
// Fixed-point projection pipeline: offsets, row rescale, ray length, divides, saturation.
module dpp_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dpp_pkg::IndexBits-1:0] in_column,
  input  logic [dpp_pkg::IndexBits-1:0] in_row,
  input  logic [dpp_pkg::RangeBits-1:0] in_range_mm,
  input  dpp_pkg::cfg_t                 cfg,
  output logic                          res_valid,
  output dpp_pkg::res_t                 res
);
  import dpp_pkg::*;

  logic [Depth-1:0] vld_r;

  logic [FocalBits-1:0] fx1;
  logic [FocalBits-1:0] fy1;
  logic [DRemBits-1:0]  bden;

  com_t                 s1_r;
  com_t                 s2_r;
  logic [BNBits-1:0]    nb_r;
  bd_t                  bd_r [0:BSteps];
  com_t                 bc_r [0:BSteps];
  sqc_t                 sb_r;
  logic [2*ABits-1:0]   asq_r;
  logic [2*BBits-1:0]   bsq_r;
  logic [2*FocalBits-1:0] fsq_r;
  sq_t                  sq_r  [0:SSteps];
  sqc_t                 sqc_r [0:SSteps];
  ln_t                  ln_r  [0:Lanes-1];
  qc_t                  lc_r;
  qd_t                  qd_r  [0:QSteps][0:Lanes-1];
  qc_t                  qc_r  [0:QSteps];
  res_t                 res_r;

  // Zero focal lengths act as one
  assign fx1  = (cfg.focal_x == '0) ? FocalBits'(1) : cfg.focal_x;
  assign fy1  = (cfg.focal_y == '0) ? FocalBits'(1) : cfg.focal_y;
  assign bden = DRemBits'({fy1, 1'b0});

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Depth-2:0], in_valid};
    end
  end

  // Offsets from the principal point, in 1/16 pixel
  logic [OffBits-1:0] px16;
  logic [OffBits-1:0] py16;
  logic [OffBits-1:0] cxe;
  logic [OffBits-1:0] cye;
  com_t               s1_nxt;

  always_comb begin
    px16 = OffBits'({in_column, 4'b0000});
    py16 = OffBits'({in_row, 4'b0000});
    cxe  = OffBits'(cfg.center_x);
    cye  = OffBits'(cfg.center_y);
    s1_nxt.rng  = in_range_mm;
    s1_nxt.xneg = px16 < cxe;
    s1_nxt.dxm  = s1_nxt.xneg ? cxe - px16 : px16 - cxe;
    s1_nxt.yneg = py16 < cye;
    s1_nxt.dym  = s1_nxt.yneg ? cye - py16 : py16 - cye;
  end

  // Row-rescale setup: N = 2*(16*dy*fx) + fy, D = 2*fy
  logic [BN2Bits-1:0] bn2;
  bd_t                bd0;

  always_comb begin
    bn2      = BN2Bits'({nb_r, 5'b00000}) + BN2Bits'(fy1);
    bd0.rem  = DRemBits'(bn2[BN2Bits-1:BBits]);
    bd0.over = DRemBits'(bn2[BN2Bits-1:BBits]) >= bden;
    bd0.rest = bn2[BBits-1:0];
    bd0.q    = '0;
  end

  // Clamp the rescaled row offset
  logic [BBits-1:0] bfin;
  logic [ABits-1:0] afin;

  always_comb begin
    afin = {bc_r[BSteps].dxm, 4'b0000};
    if (bd_r[BSteps].over || bd_r[BSteps].q > BLimit) begin
      bfin = BLimit;
    end else begin
      bfin = bd_r[BSteps].q;
    end
  end

  // Final products and divisors, by mode
  logic [RootBits-1:0]           len;
  logic [R16Bits-1:0]            r16;
  logic [ABits-1:0]              al;
  logic [R16Bits+ABits-1:0]      rx;
  logic [R16Bits+BBits-1:0]      ry;
  logic [R16Bits+FocalBits-1:0]  rz;
  logic [RangeBits+OffBits-1:0]  zx;
  logic [RangeBits+OffBits-1:0]  zy;
  ln_t                           ln_nxt [0:Lanes-1];

  always_comb begin
    len = (sq_r[SSteps].root == '0) ? RootBits'(1) : sq_r[SSteps].root;
    r16 = {sqc_r[SSteps].c.rng, 4'b0000};
    al  = {sqc_r[SSteps].c.dxm, 4'b0000};
    rx  = r16 * al;
    ry  = r16 * sqc_r[SSteps].b;
    rz  = r16 * fx1;
    zx  = sqc_r[SSteps].c.rng * sqc_r[SSteps].c.dxm;
    zy  = sqc_r[SSteps].c.rng * sqc_r[SSteps].c.dym;
    if (cfg.depth_mode) begin
      ln_nxt[0].n = FNumBits'({zx, 8'h00});
      ln_nxt[0].d = RootBits'(fx1);
      ln_nxt[1].n = FNumBits'({zy, 8'h00});
      ln_nxt[1].d = RootBits'(fy1);
      ln_nxt[2].n = '0;
      ln_nxt[2].d = RootBits'(1);
    end else begin
      ln_nxt[0].n = FNumBits'(rx);
      ln_nxt[0].d = len;
      ln_nxt[1].n = FNumBits'(ry);
      ln_nxt[1].d = len;
      ln_nxt[2].n = FNumBits'(rz);
      ln_nxt[2].d = len;
    end
  end

  // Saturate and flag
  sat_t                sx;
  sat_t                sy;
  logic [ZCmpBits-1:0] zv;
  logic                zover;
  res_t                res_nxt;

  always_comb begin
    sx    = sat_s24(qc_r[QSteps].xneg, qd_r[QSteps][0].over, qd_r[QSteps][0].q);
    sy    = sat_s24(qc_r[QSteps].yneg, qd_r[QSteps][1].over, qd_r[QSteps][1].q);
    zv    = cfg.depth_mode ? ZCmpBits'({qc_r[QSteps].rng, 4'b0000})
                           : ZCmpBits'(qd_r[QSteps][2].q);
    zover = !cfg.depth_mode && qd_r[QSteps][2].over;
    res_nxt.x = sx.val;
    res_nxt.y = sy.val;
    if (zover || zv > ZMax) begin
      res_nxt.z = {ZBits{1'b1}};
      res_nxt.clip = 1'b1;
    end else begin
      res_nxt.z = zv[ZBits-1:0];
      res_nxt.clip = sx.clip | sy.clip;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s1_r;
      nb_r  <= s1_r.dym * fx1;
      bd_r[0] <= bd0;
      bc_r[0] <= s2_r;
      for (int k = 0; k < BSteps; k++) begin
        bd_r[k+1] <= bdiv_adv(bd_r[k], bden);
        bc_r[k+1] <= bc_r[k];
      end
      sb_r.c <= bc_r[BSteps];
      sb_r.b <= bfin;
      asq_r  <= afin * afin;
      bsq_r  <= bfin * bfin;
      fsq_r  <= fx1 * fx1;
      sq_r[0].root <= '0;
      sq_r[0].rem  <= '0;
      sq_r[0].rest <= SqBits'(asq_r) + SqBits'(bsq_r) + SqBits'(fsq_r);
      sqc_r[0]     <= sb_r;
      for (int k = 0; k < SSteps; k++) begin
        sq_r[k+1]  <= sqrt_adv(sq_r[k]);
        sqc_r[k+1] <= sqc_r[k];
      end
      for (int l = 0; l < Lanes; l++) begin
        ln_r[l]    <= ln_nxt[l];
        qd_r[0][l] <= qdiv_setup(ln_r[l]);
      end
      lc_r.xneg <= sqc_r[SSteps].c.xneg;
      lc_r.yneg <= sqc_r[SSteps].c.yneg;
      lc_r.rng  <= sqc_r[SSteps].c.rng;
      qc_r[0]   <= lc_r;
      for (int k = 0; k < QSteps; k++) begin
        for (int l = 0; l < Lanes; l++) begin
          qd_r[k+1][l] <= qdiv_adv(qd_r[k][l]);
        end
        qc_r[k+1] <= qc_r[k];
      end
      res_r <= res_nxt;
    end
  end

  assign res_valid = vld_r[Depth-1];
  assign res       = res_r;

endmodule

>>> sv/depth_pixel_to_point_unit.sv
// The result passes through the 97-stage pipeline and then the output register to out_valid
// (32-step row-rescale divide, 32-step square root and 25-step final divides).
// Throughput: one transaction per cycle; the pipeline freezes only while the output
// skid register is full, and in_stall is that register's state.
// Reset (synchronous, active low) clears the valid bits, the output and skid flags,
// and sets the configuration registers to their default camera values.
module depth_pixel_to_point_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dpp_pkg::IndexBits-1:0] in_column,
  input  logic [dpp_pkg::IndexBits-1:0] in_row,
  input  logic [dpp_pkg::RangeBits-1:0] in_range_mm,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [dpp_pkg::XBits-1:0] out_point_x,
  output logic signed [dpp_pkg::XBits-1:0] out_point_y,
  output logic [dpp_pkg::ZBits-1:0]     out_point_z,
  output logic                          out_clipped,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dpp_pkg::AddrBits-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import dpp_pkg::*;

  cfg_t                  cfg_r;
  logic                  en;
  logic                  pv;
  res_t                  pres;
  logic                  out_v_r;
  logic                  out_v_nxt;
  logic                  skid_v_r;
  logic                  skid_v_nxt;
  res_t                  out_res_r;
  res_t                  skid_res_r;
  logic                  take;
  logic                  load_out;
  logic                  load_skid;
  logic                  from_skid;
  logic [RegIdxBits-1:0] reg_idx;

  assign reg_idx = paddr[AddrBits-1:2];
  assign pready  = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_mode <= 1'b0;
      cfg_r.focal_x    <= FocalReset;
      cfg_r.focal_y    <= FocalReset;
      cfg_r.center_x   <= CenterXReset;
      cfg_r.center_y   <= CenterYReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegDepthMode: cfg_r.depth_mode <= pwdata[0];
        RegFocalX:    cfg_r.focal_x    <= pwdata[FocalBits-1:0];
        RegFocalY:    cfg_r.focal_y    <= pwdata[FocalBits-1:0];
        RegCenterX:   cfg_r.center_x   <= pwdata[CenterBits-1:0];
        RegCenterY:   cfg_r.center_y   <= pwdata[CenterBits-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      RegDepthMode: prdata = 32'(cfg_r.depth_mode);
      RegFocalX:    prdata = 32'(cfg_r.focal_x);
      RegFocalY:    prdata = 32'(cfg_r.focal_y);
      RegCenterX:   prdata = 32'(cfg_r.center_x);
      RegCenterY:   prdata = 32'(cfg_r.center_y);
      default:      prdata = '0;
    endcase
  end

  // Freeze the pipeline only while the skid register holds a transaction
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  dpp_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_column   (in_column),
    .in_row      (in_row),
    .in_range_mm (in_range_mm),
    .cfg         (cfg_r),
    .res_valid   (pv),
    .res         (pres)
  );

  // Output register with skid stage
  assign take = out_v_r && !out_stall;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    load_out   = 1'b0;
    load_skid  = 1'b0;
    from_skid  = 1'b0;
    if (take) begin
      out_v_nxt = 1'b0;
    end
    if (skid_v_r) begin
      if (take) begin
        out_v_nxt  = 1'b1;
        from_skid  = 1'b1;
        skid_v_nxt = 1'b0;
      end
    end else if (pv) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
        load_out  = 1'b1;
      end else begin
        skid_v_nxt = 1'b1;
        load_skid  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (from_skid) begin
      out_res_r <= skid_res_r;
    end else if (load_out) begin
      out_res_r <= pres;
    end
    if (load_skid) begin
      skid_res_r <= pres;
    end
  end

  assign out_valid   = out_v_r;
  assign out_point_x = out_res_r.x;
  assign out_point_y = out_res_r.y;
  assign out_point_z = out_res_r.z;
  assign out_clipped = out_res_r.clip;

endmodule

>>> sv/dpp_checker.sv
// Port-level checks for the depth-pixel-to-point unit, bound to the top level.
module dpp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [dpp_pkg::XBits-1:0]     out_point_x,
  input logic [dpp_pkg::XBits-1:0]     out_point_y,
  input logic [dpp_pkg::ZBits-1:0]     out_point_z,
  input logic                          out_clipped
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_point_x) && $stable(out_point_y) &&
                               $stable(out_point_z) && $stable(out_clipped))
    else $error("stalled result changed");

  // The input side backs up only behind a stalled, full output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a stalled output");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output");

endmodule

bind depth_pixel_to_point_unit dpp_checker u_dpp_checker (.*);

>>> verif/depth_pixel_to_point_unit_test.sv
// Self-checking testbench for the depth-pixel-to-point unit: directed and random pixels.
module depth_pixel_to_point_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dpp_pkg::*;

  typedef struct {
    logic [IndexBits-1:0] col;
    logic [IndexBits-1:0] row;
    logic [RangeBits-1:0] rng;
  } pixel_t;

  typedef struct {
    logic [XBits-1:0] x;
    logic [XBits-1:0] y;
    logic [ZBits-1:0] z;
    logic             clip;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IndexBits-1:0] in_column = '0;
  logic [IndexBits-1:0] in_row = '0;
  logic [RangeBits-1:0] in_range_mm = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [XBits-1:0] out_point_x;
  logic signed [XBits-1:0] out_point_y;
  logic [ZBits-1:0] out_point_z;
  logic out_clipped;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrBits-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // camera settings as the predictor sees them
  logic                  cam_zdepth;
  logic [FocalBits-1:0]  cam_fx;
  logic [FocalBits-1:0]  cam_fy;
  logic [CenterBits-1:0] cam_cx;
  logic [CenterBits-1:0] cam_cy;

  pixel_t pending_pixels[$];
  point_t expected_points[$];
  int     errors = 0;
  int     points_seen = 0;
  int     hold_cycles = 0;
  int     send_gap = 0;
  int     recv_gap = 0;
  int     recv_hold = 0;

  // sampled at the rising edge
  logic in_stall_s = 1'b0;
  logic out_valid_s = 1'b0;

  depth_pixel_to_point_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // round-to-nearest quotient, halves up
  function automatic logic [127:0] round_div(input logic [127:0] n, input logic [127:0] d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] b;
    r = 0;
    b = 128'd1 << 126;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [XBits-1:0] clamp_signed(input logic neg, input logic [127:0] mag,
                                                   inout logic clip);
    if (neg && mag != 0) begin
      if (mag > 128'd8388608) begin
        clip = 1'b1;
        mag = 128'd8388608;
      end
      return XBits'(128'h1000000 - mag);
    end
    if (mag > 128'd8388607) begin
      clip = 1'b1;
      mag = 128'd8388607;
    end
    return XBits'(mag);
  endfunction

  // project one pixel to its camera-space point
  function automatic point_t project_pixel(input pixel_t p);
    logic [127:0] fx, fy, px, py, dxm, dym, xm, ym, zm, a, b, len, r16;
    logic xneg, yneg, clip;
    point_t q;
    fx = (cam_fx == 0) ? 1 : cam_fx;
    fy = (cam_fy == 0) ? 1 : cam_fy;
    px = 128'(p.col) << 4;
    py = 128'(p.row) << 4;
    xneg = px < cam_cx;
    yneg = py < cam_cy;
    dxm = xneg ? cam_cx - px : px - cam_cx;
    dym = yneg ? cam_cy - py : py - cam_cy;
    r16 = 128'(p.rng) * 16;
    if (cam_zdepth) begin
      xm = round_div(p.rng * dxm * 256, fx);
      ym = round_div(p.rng * dym * 256, fy);
      zm = r16;
    end else begin
      a = dxm * 16;
      b = round_div(dym * 16 * fx, fy);
      if (b > 128'd3000000000) b = 128'd3000000000;
      len = 128'(int_sqrt(a * a + b * b + fx * fx));
      if (len == 0) len = 1;
      xm = round_div(r16 * a, len);
      ym = round_div(r16 * b, len);
      zm = round_div(r16 * fx, len);
    end
    clip = 1'b0;
    q.x = clamp_signed(xneg, xm, clip);
    q.y = clamp_signed(yneg, ym, clip);
    if (zm > 128'd1048575) begin
      clip = 1'b1;
      zm = 128'd1048575;
    end
    q.z = ZBits'(zm);
    q.clip = clip;
    return q;
  endfunction

  // drive pixels at the falling edge; hold while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_s) begin
        if (send_gap == 0 && pending_pixels.size() > 0) begin
          in_column <= pending_pixels[0].col;
          in_row <= pending_pixels[0].row;
          in_range_mm <= pending_pixels[0].rng;
          void'(pending_pixels.pop_front());
          send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_pixels.size() > 0) begin
          in_valid <= 1'b1;
          in_column <= pending_pixels[0].col;
          in_row <= pending_pixels[0].row;
          in_range_mm <= pending_pixels[0].rng;
          void'(pending_pixels.pop_front());
          send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : 0;
        end
      end
      // receiver stall
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid_s) recv_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 8) : 0;
      end
    end
  end

  // predict on accepted pixels, check accepted points
  always @(posedge clk) begin
    point_t q;
    point_t exp_pt;
    pixel_t p;
    in_stall_s <= in_stall;
    out_valid_s <= out_valid;
    if (rst_n && in_valid && !in_stall) begin
      p.col = in_column;
      p.row = in_row;
      p.rng = in_range_mm;
      expected_points.push_back(project_pixel(p));
    end
    if (rst_n && out_valid && !out_stall) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time, out_point_x,
                 out_point_y, out_point_z);
      end else begin
        exp_pt = expected_points.pop_front();
        q.x = out_point_x;
        q.y = out_point_y;
        q.z = out_point_z;
        q.clip = out_clipped;
        if (q.x !== exp_pt.x || q.y !== exp_pt.y || q.z !== exp_pt.z ||
            q.clip !== exp_pt.clip) begin
          errors++;
          $display("%0t: point mismatch expected x=%0d y=%0d z=%0d clip=%0b", $time,
                   $signed(exp_pt.x), $signed(exp_pt.y), exp_pt.z, exp_pt.clip);
          $display("%0t:                  actual x=%0d y=%0d z=%0d clip=%0b", $time,
                   $signed(q.x), $signed(q.y), q.z, q.clip);
        end
      end
    end
  end

  task automatic write_reg(input logic [RegIdxBits-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegDepthMode: cam_zdepth = val[0];
      RegFocalX:    cam_fx = val[FocalBits-1:0];
      RegFocalY:    cam_fy = val[FocalBits-1:0];
      RegCenterX:   cam_cx = val[CenterBits-1:0];
      RegCenterY:   cam_cy = val[CenterBits-1:0];
      default: ;
    endcase
  endtask

  task automatic add_pixel(input int c, input int r, input int d);
    pixel_t p;
    p.col = IndexBits'(c);
    p.row = IndexBits'(r);
    p.rng = RangeBits'(d);
    pending_pixels.push_back(p);
  endtask

  // wait for the pipeline to drain, then past its latency
  task automatic drain;
    while (pending_pixels.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (Depth + 10) @(posedge clk);
  endtask

  // mostly realistic pixels, some full-range noise
  task automatic add_random(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535));
      else
        add_pixel($urandom_range(0, 640), $urandom_range(0, 480), $urandom_range(0, 8000));
    end
  endtask

  task automatic set_camera(input logic m, input int fx, input int fy, input int cx,
                            input int cy);
    write_reg(RegDepthMode, 32'(m));
    write_reg(RegFocalX, fx);
    write_reg(RegFocalY, fy);
    write_reg(RegCenterX, cx);
    write_reg(RegCenterY, cy);
  endtask

  initial begin
    cam_zdepth = 1'b0;
    cam_fx = FocalReset;
    cam_fy = FocalReset;
    cam_cx = CenterXReset;
    cam_cy = CenterYReset;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset camera, corners, zero and full range
    add_pixel(0, 0, 0);
    add_pixel(4095, 4095, 65535);
    add_pixel(0, 4095, 65535);
    add_pixel(4095, 0, 1);
    add_pixel(160, 120, 1000);
    add_pixel(320, 240, 65535);
    drain();
    // zero focal lengths, z-depth mode, overflow
    set_camera(1'b1, 0, 0, 65535, 0);
    add_pixel(0, 0, 65535);
    add_pixel(4095, 4095, 65535);
    add_pixel(4095, 4095, 0);
    add_pixel(2000, 1000, 3);
    drain();
    // radial with tiny fy: row offset limit
    set_camera(1'b0, 1048575, 0, 0, 65535);
    add_pixel(0, 0, 65535);
    add_pixel(4095, 4095, 65535);
    add_pixel(1, 4095, 500);
    add_pixel(4095, 0, 65535);
    drain();
    set_camera(1'b0, 256, 1048575, 65535, 65535);
    add_pixel(4095, 4095, 65535);
    add_pixel(0, 0, 12345);
    drain();

    // random phases over several camera settings
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) set_camera(1'b0, 76800, 76800, 2560, 1920);
      else set_camera(1'($urandom_range(0, 1)), $urandom_range(256, 1048575),
                      $urandom_range(256, 1048575), $urandom_range(0, 65535),
                      $urandom_range(0, 65535));
      if (ph == 2) hold_cycles = 300;
      add_random(150);
      drain();
    end

    $display("Covered %0d points over radial and z-depth cameras, corner focal lengths,",
             points_seen);
    $display("principal points and ranges, with random gaps and a long output hold.");
    if (errors == 0) begin
      $display("depth_pixel_to_point_unit_test: clean");
    end else begin
      $display("depth_pixel_to_point_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("depth_pixel_to_point_unit_test: errors");
    $finish;
  end

endmodule
